>>> rtl/cbt_pkg.sv
// Shared types and constants of the CSV byte tokenizer.
// No dependencies; imported by every module of the block.
package cbt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] SEP_RESET  = 8'd44;
  localparam logic       CRLF_RESET = 1'b0;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic {
    CFG_SEPARATOR = 1'b0,
    CFG_CRLF_MODE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       field_end;
    logic       record_end;
    logic       parse_error;
  } res_t;

  // one queue entry: the one or two results of an item
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } cmd_t;

endpackage

>>> rtl/cbt_front.sv
// Front end: configuration registers, tokenizer state and per-item classification.
// Depends on cbt_pkg; emits one queue entry per item that has results.
module cbt_front import cbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       take_i,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  typedef struct packed {
    logic emit;
    res_t res;
    logic open_q;
    logic hold_cr;
  } outside_t;

  logic [7:0] sep_q;
  logic       crlf_q;
  logic       inq_q, inq_d;
  logic       qs_q, qs_d;
  logic       cr_q, cr_d;
  logic       rec_q, rec_d;
  res_t       r [2];
  logic [1:0] n;
  outside_t   o;

  function automatic res_t mk(input logic [7:0] b, input logic has, input logic fe,
                              input logic re, input logic err);
    res_t x;
    x.out_byte    = has ? b : 8'd0;
    x.has_byte    = has;
    x.field_end   = fe;
    x.record_end  = re;
    x.parse_error = err;
    return x;
  endfunction

  function automatic outside_t outside_f(input logic [7:0] b, input logic [7:0] sep,
                                         input logic crlf);
    outside_t x;
    x = '0;
    if (b == sep) begin
      x.emit = 1'b1;
      x.res  = mk(8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
    end else if (b == CH_QUOTE) begin
      x.open_q = 1'b1;
    end else if (b == CH_LF && !crlf) begin
      x.emit = 1'b1;
      x.res  = mk(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
    end else if (b == CH_CR && crlf) begin
      x.hold_cr = 1'b1;
    end else begin
      x.emit = 1'b1;
      x.res  = mk(b, 1'b1, 1'b0, 1'b0, 1'b0);
    end
    return x;
  endfunction

  always_comb begin
    inq_d = inq_q;
    qs_d  = qs_q;
    cr_d  = cr_q;
    rec_d = rec_q;
    r[0]  = '0;
    r[1]  = '0;
    n     = 2'd0;
    o     = outside_f(in_byte_i, sep_q, crlf_q);
    if (stream_end_i) begin
      if (inq_q && !qs_q) begin
        r[0] = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        n    = 2'd1;
      end else begin
        if (cr_q) begin
          r[n[0]] = mk(CH_CR, 1'b1, 1'b0, 1'b0, 1'b0);
          n       = n + 2'd1;
        end
        if (rec_q || inq_q || cr_q) begin
          r[n[0]] = mk(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
          n       = n + 2'd1;
        end
      end
      inq_d = 1'b0;
      qs_d  = 1'b0;
      cr_d  = 1'b0;
      rec_d = 1'b0;
    end else if (inq_q) begin
      rec_d = 1'b1;
      if (qs_q) begin
        qs_d = 1'b0;
        if (in_byte_i == CH_QUOTE) begin
          r[0] = mk(CH_QUOTE, 1'b1, 1'b0, 1'b0, 1'b0);
          n    = 2'd1;
        end else begin
          inq_d = o.open_q;
          cr_d  = o.hold_cr;
          rec_d = !(o.emit && o.res.record_end);
          if (o.emit) begin
            r[0] = o.res;
            n    = 2'd1;
          end
        end
      end else if (in_byte_i == CH_QUOTE) begin
        qs_d = 1'b1;
      end else begin
        r[0] = mk(in_byte_i, 1'b1, 1'b0, 1'b0, 1'b0);
        n    = 2'd1;
      end
    end else if (cr_q) begin
      cr_d = 1'b0;
      if (in_byte_i == CH_LF) begin
        rec_d = 1'b0;
        r[0]  = mk(8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        n     = 2'd1;
      end else begin
        r[0]  = mk(CH_CR, 1'b1, 1'b0, 1'b0, 1'b0);
        n     = 2'd1;
        inq_d = o.open_q;
        cr_d  = o.hold_cr;
        rec_d = !(o.emit && o.res.record_end);
        if (o.emit) begin
          r[1] = o.res;
          n    = 2'd2;
        end
      end
    end else begin
      inq_d = o.open_q;
      cr_d  = o.hold_cr;
      rec_d = !(o.emit && o.res.record_end);
      if (o.emit) begin
        r[0] = o.res;
        n    = 2'd1;
      end
    end
  end

  assign cmd_valid_o = take_i && (n != 2'd0);
  assign cmd_o.two   = n[1];
  assign cmd_o.r0    = r[0];
  assign cmd_o.r1    = r[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q  <= SEP_RESET;
      crlf_q <= CRLF_RESET;
      inq_q  <= 1'b0;
      qs_q   <= 1'b0;
      cr_q   <= 1'b0;
      rec_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SEPARATOR: sep_q  <= cfg_data_i;
          CFG_CRLF_MODE: crlf_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (take_i) begin
        inq_q <= inq_d;
        qs_q  <= qs_d;
        cr_q  <= cr_d;
        rec_q <= rec_d;
      end
    end
  end

endmodule

>>> rtl/cbt_queue.sv
// Short queue of result entries between front and back end.
// Depends on cbt_pkg for the entry type.
module cbt_queue import cbt_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = cnt_q == FullCnt;
  assign empty_o   = cnt_q == '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == LastPtr) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == LastPtr) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/cbt_back.sv
// Back end: walks the one or two results of the head queue entry.
// Depends on cbt_pkg; drives the result side of the block.
module cbt_back import cbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t head_i,
  input  logic head_empty_i,
  input  logic pop_i,
  output logic head_rd_o,
  output res_t res_o,
  output logic last_o
);

  logic sub_q;
  logic take;

  assign take      = pop_i && !head_empty_i;
  assign res_o     = sub_q ? head_i.r1 : head_i.r0;
  assign last_o    = sub_q || !head_i.two;
  assign head_rd_o = take && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (take) begin
      sub_q <= !last_o;
    end
  end

endmodule

>>> rtl/csv_byte_tokenizer.sv
// Top level of the CSV byte tokenizer: front end, result queue and back end.
// Depends on cbt_pkg, cbt_front, cbt_queue and cbt_back.
//
// Input channel: an item (in_byte_i, stream_end_i) is taken at a clock edge
// with push high and full low. One item per cycle is accepted as long as the
// result queue has room. Each item gives zero, one or two results.
// Result channel: while empty is low the oldest result is on the result ports;
// it is taken at an edge with pop high. An item's results enter the queue on
// acceptance and reach the ports after older ones. One result leaves per
// cycle while pop is high, so an item with two results leaves one at a time;
// the Depth-entry queue between front and back absorbs that and any stall on
// pop. When pop stays low the queue fills and full rises; nothing is dropped.
// Configuration: cfg_valid_i with cfg_index_i (0 separator, 1 CRLF mode) and
// cfg_data_i; cfg_ready_o is always high. Write only while the block is idle.
// Reset: separator is ',', LF mode, tokenizer state cleared, queue empty.
module csv_byte_tokenizer import cbt_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       field_end_o,
  output logic       record_end_o,
  output logic       parse_error_o,
  output logic       last_o
);

  logic take;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t head;
  logic head_rd;
  res_t res;

  assign cfg_ready_o = 1'b1;
  assign take        = push && !full;

  cbt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .take_i       (take),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  cbt_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd),
    .rd_i      (head_rd),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  cbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (empty),
    .pop_i        (pop),
    .head_rd_o    (head_rd),
    .res_o        (res),
    .last_o       (last_o)
  );

  assign out_byte_o    = res.out_byte;
  assign has_byte_o    = res.has_byte;
  assign field_end_o   = res.field_end;
  assign record_end_o  = res.record_end;
  assign parse_error_o = res.parse_error;

endmodule
